### rtl/core/pli_pkg.sv
package pli_pkg;

   localparam int DataWidth = 32;
   localparam int EntryIndexWidth = 8;
   localparam int PointCountWidth = 9;
   localparam int StatusWidth = 2;
   localparam int MaxPointsDefault = 256;

   // fraction of the span in 16 fraction bits, one extra bit for the full span
   localparam int FracBits = 16;
   localparam int FracWidth = FracBits + 1;
   localparam int ProdWidth = FracWidth + 1 + DataWidth + 1;

   typedef enum logic [0:0] {
      OP_LOAD = 1'b0,
      OP_EVAL = 1'b1
   } op_type;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_INTERP = 2'd0,
      STATUS_BELOW  = 2'd1,
      STATUS_ABOVE  = 2'd2,
      STATUS_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIRST,
      S_LAST,
      S_SEARCH,
      S_LOWER,
      S_UPPER,
      S_DIV,
      S_MUL,
      S_ADD,
      S_FIN
   } state_type;

endpackage

### rtl/core/pli_if.sv
interface pli_req_if;
   import pli_pkg::*;

   logic                        valid;
   logic                        ready;
   op_type                      op;
   logic [EntryIndexWidth-1:0]  entry_index;
   logic [DataWidth-1:0]        abscissa;
   logic signed [DataWidth-1:0] ordinate;

   modport source (output valid, output op, output entry_index, output abscissa,
                   output ordinate, input ready);
   modport sink   (input valid, input op, input entry_index, input abscissa,
                   input ordinate, output ready);
endinterface

interface pli_rsp_if;
   import pli_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [DataWidth-1:0] value;
   status_type                  status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

### rtl/core/pli_table_mem.sv
module pli_table_mem #(
   parameter int DEPTH = pli_pkg::MaxPointsDefault,
   parameter int AW    = $clog2(DEPTH),
   parameter int DW    = 2 * pli_pkg::DataWidth
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   import pli_pkg::*;

   // abscissa in the upper half, ordinate in the lower half
   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/pli_frac_div.sv
module pli_frac_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pli_pkg::DataWidth-1:0]  dividend,
   input  logic [pli_pkg::DataWidth-1:0]  divisor,
   output logic                           done,
   output logic [pli_pkg::FracBits-1:0]   quotient
);
   import pli_pkg::*;

   // restoring division, one quotient bit a cycle; dividend is below divisor
   localparam int StepWidth = $clog2(FracBits);
   localparam logic [StepWidth-1:0] LastStep = StepWidth'(FracBits - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   logic [DataWidth-1:0]  rem_ff, div_ff;
   logic [FracBits-1:0]   quot_ff;

   logic [DataWidth:0]    rem_shift;
   logic                  fits;
   logic [DataWidth-1:0]  rem_next;

   always_comb begin
      rem_shift = {rem_ff, 1'b0};
      fits      = rem_shift >= {1'b0, div_ff};
      rem_next  = fits ? DataWidth'(rem_shift - {1'b0, div_ff}) : rem_shift[DataWidth-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 1'b1;
         if (step_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= rem_next;
         quot_ff <= {quot_ff[FracBits-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

### rtl/core/piecewise_linear_interpolator_top.sv
// load transfer: written into the table as it is taken, the next request can follow at once
// evaluate: an empty table needs no read, a clamped query reads the first and if needed the
//   last breakpoint, interpolation searches and divides; next request once handed over
// the search takes one step a cycle, set by the table's one registered read port;
//   the fraction divider gives one quotient bit a cycle and registers its done flag
// synchronous active-high reset clears the point count, the sequencer and the response valid
module piecewise_linear_interpolator_top #(
   parameter int MAX_POINTS = pli_pkg::MaxPointsDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   pli_req_if.sink                              req_ch,
   pli_rsp_if.source                            rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [pli_pkg::PointCountWidth-1:0]  csr_wr_data
);
   import pli_pkg::*;

   // table address, and index width able to hold the point count itself
   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int CW = (NW > PointCountWidth) ? NW : PointCountWidth;
   localparam int MW = 2 * DataWidth;
   localparam logic [FracWidth-1:0] FracOne = FracWidth'(1) << FracBits;
   localparam logic signed [ProdWidth-1:0] RoundHalf = ProdWidth'(1) << (FracBits - 1);

   // sequencer and configuration
   state_type                    state_ff, state_in;
   logic [PointCountWidth-1:0]   point_count_ff, point_count_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // working registers of one evaluate
   logic [DataWidth-1:0]         x_ff, x_in;
   logic [NW-1:0]                n_ff, n_in;
   logic [NW-1:0]                lo_ff, lo_in;
   logic [NW-1:0]                hi_ff, hi_in;
   logic [NW-1:0]                mid_ff, mid_in;
   logic [NW-1:0]                idx_ff, idx_in;
   logic [DataWidth-1:0]         a0_ff, a0_in;
   logic signed [DataWidth-1:0]  y0_ff, y0_in;
   logic signed [DataWidth-1:0]  y1_ff, y1_in;
   logic [FracWidth-1:0]         frac_ff, frac_in;
   logic signed [ProdWidth-1:0]  prod_ff, prod_in;
   logic signed [DataWidth-1:0]  res_value_ff, res_value_in;
   status_type                   res_status_ff, res_status_in;
   logic signed [DataWidth-1:0]  rsp_value_ff, rsp_value_in;
   status_type                   rsp_status_ff, rsp_status_in;

   // table ports
   logic                         mem_wr_en;
   logic [AW-1:0]                mem_wr_addr;
   logic [MW-1:0]                mem_wr_data;
   logic                         mem_rd_en;
   logic [AW-1:0]                mem_rd_addr;
   logic [MW-1:0]                mem_rd_data;
   logic [DataWidth-1:0]         rd_abs;
   logic signed [DataWidth-1:0]  rd_ord;

   // fraction divider
   logic                         div_start;
   logic [DataWidth-1:0]         div_dividend;
   logic [DataWidth-1:0]         div_divisor;
   logic                         div_done;
   logic [FracBits-1:0]          div_quot;

   // combinational helpers
   logic                         req_xfer;
   logic                         rsp_free;
   logic [NW-1:0]                n_calc;
   logic [NW-1:0]                lo_new, hi_new, i_calc;
   logic [NW:0]                  mid_sum;
   logic signed [DataWidth:0]    ord_diff;
   logic signed [ProdWidth-1:0]  rounded;
   logic signed [ProdWidth-1:0]  scaled;

   assign rd_abs = mem_rd_data[MW-1:DataWidth];
   assign rd_ord = mem_rd_data[DataWidth-1:0];

   pli_table_mem #(
      .DEPTH (MAX_POINTS),
      .AW    (AW),
      .DW    (MW)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pli_frac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // requests are taken only between evaluates; the response register parts the two sides
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // points in use, a count above the table size acts as the table size
   always_comb begin
      if (CW'(point_count_ff) > CW'(MAX_POINTS)) begin
         n_calc = NW'(MAX_POINTS);
      end else begin
         n_calc = NW'(point_count_ff);
      end
   end

   // loads go straight into the table, slots beyond the table are dropped
   always_comb begin
      mem_wr_en   = req_xfer && (req_ch.op == OP_LOAD)
                    && (32'(req_ch.entry_index) < 32'(MAX_POINTS));
      mem_wr_addr = AW'(req_ch.entry_index);
      mem_wr_data = {req_ch.abscissa, req_ch.ordinate};
   end

   // divider operands: offset of the query into the span, and the span
   assign div_dividend = x_ff - a0_ff;
   assign div_divisor  = rd_abs - a0_ff;

   // one binary search step on the probe that just came back
   always_comb begin
      lo_new = lo_ff;
      hi_new = hi_ff;
      if (rd_abs <= x_ff) begin
         lo_new = mid_ff + 1'b1;
      end else begin
         hi_new = mid_ff;
      end
      mid_sum = {1'b0, lo_new} + {1'b0, hi_new};
      // last breakpoint not above the query, kept inside 0..count-2
      i_calc = (lo_new == '0) ? '0 : NW'(lo_new - 1'b1);
      if (i_calc > NW'(n_ff - NW'(2))) begin
         i_calc = NW'(n_ff - NW'(2));
      end
   end

   // interpolation arithmetic, product registered before the rounding add
   always_comb begin
      ord_diff = {y1_ff[DataWidth-1], y1_ff} - {y0_ff[DataWidth-1], y0_ff};
      prod_in  = $signed({1'b0, frac_ff}) * ord_diff;
      rounded  = prod_ff + RoundHalf;
      scaled   = rounded >>> FracBits;
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      point_count_in = csr_wr_en ? csr_wr_data : point_count_ff;
      x_in           = x_ff;
      n_in           = n_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      idx_in         = idx_ff;
      a0_in          = a0_ff;
      y0_in          = y0_ff;
      y1_in          = y1_ff;
      frac_in        = frac_ff;
      res_value_in   = res_value_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = '0;
      div_start      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req_ch.op == OP_EVAL)) begin
               x_in = req_ch.abscissa;
               n_in = n_calc;
               if (n_calc == '0) begin
                  res_value_in  = '0;
                  res_status_in = STATUS_EMPTY;
                  state_in      = S_FIN;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = '0;
                  state_in    = S_FIRST;
               end
            end
         end

         // first breakpoint back: clamp below
         S_FIRST: begin
            if (x_ff <= rd_abs) begin
               res_value_in  = rd_ord;
               res_status_in = STATUS_BELOW;
               state_in      = S_FIN;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(n_ff - 1'b1);
               state_in    = S_LAST;
            end
         end

         // last breakpoint back: clamp above, otherwise open the search
         S_LAST: begin
            if (x_ff >= rd_abs) begin
               res_value_in  = rd_ord;
               res_status_in = STATUS_ABOVE;
               state_in      = S_FIN;
            end else begin
               lo_in       = '0;
               hi_in       = n_ff;
               mid_in      = n_ff >> 1;
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(n_ff >> 1);
               state_in    = S_SEARCH;
            end
         end

         // upper-bound search, one probe read a cycle
         S_SEARCH: begin
            lo_in = lo_new;
            hi_in = hi_new;
            mem_rd_en = 1'b1;
            if (lo_new < hi_new) begin
               mid_in      = mid_sum[NW:1];
               mem_rd_addr = AW'(mid_sum[NW:1]);
            end else begin
               idx_in      = i_calc;
               mem_rd_addr = AW'(i_calc);
               state_in    = S_LOWER;
            end
         end

         // lower end of the span back, fetch the upper end
         S_LOWER: begin
            a0_in       = rd_abs;
            y0_in       = rd_ord;
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(idx_ff + 1'b1);
            state_in    = S_UPPER;
         end

         // upper end back: degenerate span, end points of the fraction, or divide
         S_UPPER: begin
            y1_in = rd_ord;
            if (rd_abs <= a0_ff) begin
               res_value_in  = y0_ff;
               res_status_in = STATUS_INTERP;
               state_in      = S_FIN;
            end else if (x_ff <= a0_ff) begin
               frac_in  = '0;
               state_in = S_MUL;
            end else if (x_ff >= rd_abs) begin
               frac_in  = FracOne;
               state_in = S_MUL;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end

         S_DIV: begin
            if (div_done) begin
               frac_in  = {1'b0, div_quot};
               state_in = S_MUL;
            end
         end

         S_MUL: begin
            state_in = S_ADD;
         end

         // round to nearest, ties upward, then add to the lower ordinate
         S_ADD: begin
            res_value_in  = y0_ff + scaled[DataWidth-1:0];
            res_status_in = STATUS_INTERP;
            state_in      = S_FIN;
         end

         // hand the result over once the response register is free
         S_FIN: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         point_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         point_count_ff <= point_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      n_ff          <= n_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      idx_ff        <= idx_in;
      a0_ff         <= a0_in;
      y0_ff         <= y0_in;
      y1_ff         <= y1_in;
      frac_ff       <= frac_in;
      prod_ff       <= prod_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.value  = rsp_value_ff;
   assign rsp_ch.status = rsp_status_ff;

endmodule
